### design/sbp_pkg.sv
// ----------------------------------------------------------------------------
// sbp_pkg
// Shared types and constants for the screen blend pixel pipeline.
// ----------------------------------------------------------------------------
package sbp_pkg;

   localparam int LANE_W    = 8;
   localparam int NUM_LANES = 4;
   localparam int PIXEL_W   = LANE_W * NUM_LANES;
   localparam int PROD_W    = 2 * LANE_W;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 8;

   localparam int ALPHA_LANE = NUM_LANES - 1;

   localparam logic [CSR_IDX_W-1:0] CSR_OPACITY         = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_USE_OPACITY     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD_DEST_ALPHA = 2'd2;

   localparam logic [LANE_W-1:0] OPACITY_RESET = 8'hff;
   localparam logic [LANE_W-1:0] BYTE_MAX      = 8'hff;
   localparam logic [PROD_W-1:0] WORD_MAX      = 16'hffff;

   typedef struct packed {
      logic [PIXEL_W-1:0] dest_pixel;
      logic [PIXEL_W-1:0] src_pixel;
      logic               last_pixel;
   } req_payload_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] result_pixel;
      logic               last_out;
   } rsp_payload_type;

   typedef struct packed {
      logic [LANE_W-1:0] opacity;
      logic              use_opacity;
      logic              hold_dest_alpha;
   } cfg_type;

   // After the factor stage: inverted destination and blend factor per lane.
   typedef struct packed {
      logic [NUM_LANES-1:0][LANE_W-1:0] inv_dest;
      logic [NUM_LANES-1:0][LANE_W-1:0] factor;
      logic [LANE_W-1:0]                dest_alpha;
      logic                             last;
   } factor_type;

   // After the product stage: full products per lane.
   typedef struct packed {
      logic [NUM_LANES-1:0][PROD_W-1:0] product;
      logic [LANE_W-1:0]                dest_alpha;
      logic                             last;
   } product_type;

endpackage

### design/sbp_factor_stage.sv
// ----------------------------------------------------------------------------
// sbp_factor_stage
// First pipeline stage: computes the per-lane source factor and the inverted
// destination bytes.
// ----------------------------------------------------------------------------
module sbp_factor_stage import sbp_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  cfg_type         cfg,
   input  logic            up_valid,
   input  req_payload_type up_data,
   output logic            up_ready,
   output logic            dn_valid,
   output factor_type      dn_data,
   input  logic            dn_ready
);

   logic       valid_ff, valid_in;
   factor_type data_ff, data_in;

   always_comb begin
      logic [LANE_W-1:0] src_byte;
      logic [LANE_W-1:0] dest_byte;
      logic [PROD_W-1:0] scaled;
      logic [PROD_W-1:0] diff;
      data_in = '0;
      for (int i = 0; i < NUM_LANES; i++) begin
         src_byte  = up_data.src_pixel[i*LANE_W +: LANE_W];
         dest_byte = up_data.dest_pixel[i*LANE_W +: LANE_W];
         scaled    = src_byte * cfg.opacity;
         diff      = WORD_MAX - scaled;
         data_in.inv_dest[i] = BYTE_MAX - dest_byte;
         if (cfg.use_opacity) begin
            data_in.factor[i] = diff[PROD_W-1:LANE_W];
         end else begin
            data_in.factor[i] = BYTE_MAX - src_byte;
         end
      end
      data_in.dest_alpha = up_data.dest_pixel[ALPHA_LANE*LANE_W +: LANE_W];
      data_in.last       = up_data.last_pixel;
   end

   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

### design/sbp_product_stage.sv
// ----------------------------------------------------------------------------
// sbp_product_stage
// Second pipeline stage: multiplies inverted destination by the factor.
// ----------------------------------------------------------------------------
module sbp_product_stage import sbp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        up_valid,
   input  factor_type  up_data,
   output logic        up_ready,
   output logic        dn_valid,
   output product_type dn_data,
   input  logic        dn_ready
);

   logic        valid_ff, valid_in;
   product_type data_ff, data_in;

   always_comb begin
      data_in = '0;
      for (int i = 0; i < NUM_LANES; i++) begin
         data_in.product[i] = up_data.inv_dest[i] * up_data.factor[i];
      end
      data_in.dest_alpha = up_data.dest_alpha;
      data_in.last       = up_data.last;
   end

   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

### design/sbp_result_stage.sv
// ----------------------------------------------------------------------------
// sbp_result_stage
// Last pipeline stage: forms the result bytes and holds the output register.
// ----------------------------------------------------------------------------
module sbp_result_stage import sbp_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  cfg_type         cfg,
   input  logic            up_valid,
   input  product_type     up_data,
   output logic            up_ready,
   output logic            dn_valid,
   output rsp_payload_type dn_data,
   input  logic            dn_stall
);

   logic            valid_ff, valid_in;
   rsp_payload_type data_ff, data_in;

   always_comb begin
      logic [PROD_W-1:0] prod;
      data_in = '0;
      for (int i = 0; i < NUM_LANES; i++) begin
         prod = up_data.product[i];
         data_in.result_pixel[i*LANE_W +: LANE_W] = BYTE_MAX - prod[PROD_W-1:LANE_W];
      end
      // Hold-alpha mode passes the destination alpha byte through untouched.
      if (cfg.hold_dest_alpha) begin
         data_in.result_pixel[ALPHA_LANE*LANE_W +: LANE_W] = up_data.dest_alpha;
      end
      data_in.last_out = up_data.last;
   end

   assign up_ready = !valid_ff || !dn_stall;
   assign valid_in = up_ready ? up_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

### design/screen_blend_pixel.sv
// A request passes through the factor, product and result registers before its
// response is offered on the response port.
// Throughput: one pixel per cycle; each of the three stages moves one pixel a
// clock, and a stall holds the stages that are full without losing data.
// Reset: synchronous and active high; it empties the pipeline and sets opacity
// to 255 with opacity mode and hold-alpha mode off.
// ----------------------------------------------------------------------------
// screen_blend_pixel
// Screen blend of one ARGB8888 destination and source pixel pair, pipelined
// as factor, product and result stages with a register write port.
// ----------------------------------------------------------------------------
module screen_blend_pixel import sbp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wen,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_payload_type       req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_payload_type       rsp_payload
);

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   logic        req_ready;
   logic        fac_valid, fac_ready;
   factor_type  fac_data;
   logic        prd_valid, prd_ready;
   product_type prd_data;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         case (csr_index)
            CSR_OPACITY:         cfg_in.opacity         = csr_wdata;
            CSR_USE_OPACITY:     cfg_in.use_opacity     = csr_wdata[0];
            CSR_HOLD_DEST_ALPHA: cfg_in.hold_dest_alpha = csr_wdata[0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.opacity         <= OPACITY_RESET;
         cfg_ff.use_opacity     <= 1'b0;
         cfg_ff.hold_dest_alpha <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   sbp_factor_stage u_factor (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .up_valid (req_valid),
      .up_data  (req_payload),
      .up_ready (req_ready),
      .dn_valid (fac_valid),
      .dn_data  (fac_data),
      .dn_ready (fac_ready)
   );

   sbp_product_stage u_product (
      .clock    (clock),
      .reset    (reset),
      .up_valid (fac_valid),
      .up_data  (fac_data),
      .up_ready (fac_ready),
      .dn_valid (prd_valid),
      .dn_data  (prd_data),
      .dn_ready (prd_ready)
   );

   sbp_result_stage u_result (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .up_valid (prd_valid),
      .up_data  (prd_data),
      .up_ready (prd_ready),
      .dn_valid (rsp_valid),
      .dn_data  (rsp_payload),
      .dn_stall (rsp_stall)
   );

   assign req_stall = !req_ready;

endmodule

### design/sbp_checker.sv
// ----------------------------------------------------------------------------
// sbp_checker
// Port-level checks for screen_blend_pixel, attached by a bind statement.
// ----------------------------------------------------------------------------
module sbp_checker import sbp_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input rsp_payload_type       rsp_payload
);

   // A stalled response transaction keeps its data.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("response changed while stalled");

   // With the output side free, the pipeline always takes a new pixel.
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("request stalled while the output side is free");

   // An accepted pixel reaches the output if the output side does not stall meanwhile.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) ##1 !rsp_stall ##1 !rsp_stall |=> rsp_valid)
      else $error("response missing after pipeline latency");

   // The pipeline comes out of reset empty.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind screen_blend_pixel sbp_checker u_sbp_checker (.*);
